// ===== hdl/mrrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrt_pkg
// Types, codes and helpers shared by the memory request retry tracker.
// ----------------------------------------------------------------------------
package mrrt_pkg;

  localparam int unsigned MaxPayloadDef  = 1024;
  localparam logic [3:0]  MaxAttemptsRst = 4'd3;

  // Result queue geometry.
  localparam int unsigned RqDepth = 4;
  localparam int unsigned RqPtrW  = 2;
  localparam int unsigned RqCntW  = 3;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_CONNECT = 2'd2,
    REQ_REPLY   = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    RK_BYTES   = 3'd0,
    RK_TIMEOUT = 3'd1,
    RK_DISC    = 3'd2,
    RK_NOCONN  = 3'd3,
    RK_OTHER   = 3'd4
  } reply_kind_e;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_WACK  = 2'd1,
    OP_ERROR = 2'd2,
    OP_OTHER = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_FINAL   = 2'd0,
    ACT_CONNECT = 2'd1,
    ACT_SEND    = 2'd2,
    ACT_CLOSE   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_INVALID    = 4'd1,
    ERR_CONN_FAIL  = 4'd2,
    ERR_TIMEOUT    = 4'd3,
    ERR_DISCONN    = 4'd4,
    ERR_MALFORMED  = 4'd5,
    ERR_MISMATCH   = 4'd6,
    ERR_REMOTE     = 4'd7,
    ERR_UNEXPECTED = 4'd8
  } err_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_CONNECT = 3'b010,
    PH_REPLY   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [15:0] length;
    logic [15:0] deadline_ms;
    logic        link_up;
    logic [2:0]  reply_kind;
    logic        decode_ok;
    logic [1:0]  resp_opcode;
    logic [31:0] resp_id;
    logic [31:0] resp_address;
    logic [15:0] resp_payload_len;
    logic [7:0]  resp_status;
  } item_t;

  typedef struct packed {
    action_e     action;
    logic        send_is_write;
    logic [31:0] req_tag;
    logic [31:0] send_address;
    logic [15:0] send_length;
    logic [15:0] send_deadline_ms;
    err_e        error_code;
    logic [7:0]  peer_status;
    logic [3:0]  attempts;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] next_id;
    phase_e      phase;
    logic        cur_is_write;
    logic [31:0] cur_id;
    logic [31:0] cur_address;
    logic [15:0] cur_length;
    logic [15:0] cur_deadline;
    logic [3:0]  attempt_count;
  } state_t;

  // Builds one result; the request fields are only carried on a send.
  function automatic result_t mk_res(action_e a, logic [31:0] id, logic wr,
                                     logic [31:0] addr, logic [15:0] len,
                                     logic [15:0] dl, err_e e, logic [7:0] status,
                                     logic [3:0] att, logic last);
    result_t r;
    r                  = '0;
    r.action           = a;
    r.req_tag          = id;
    r.error_code       = e;
    r.peer_status      = status;
    r.attempts         = att;
    r.last             = last;
    if (a == ACT_SEND) begin
      r.send_is_write    = wr;
      r.send_address     = addr;
      r.send_length      = len;
      r.send_deadline_ms = dl;
    end
    return r;
  endfunction

endpackage

// ===== hdl/mrrt_step.sv =====
// ----------------------------------------------------------------------------
// mrrt_step
// Next-state and result logic for one event against the tracker state.
// ----------------------------------------------------------------------------
module mrrt_step #(
  parameter int unsigned MAX_PAYLOAD = mrrt_pkg::MaxPayloadDef
) (
  input  mrrt_pkg::item_t   item_i,
  input  mrrt_pkg::state_t  state_i,
  input  logic [3:0]        max_att_i,
  output mrrt_pkg::state_t  state_o,
  output mrrt_pkg::result_t res0_o,
  output mrrt_pkg::result_t res1_o,
  output logic [1:0]        num_res_o
);
  import mrrt_pkg::*;

  localparam logic [16:0] MaxLen = 17'(MAX_PAYLOAD);

  logic [31:0] nid;
  logic [3:0]  limit;
  logic [3:0]  att_inc;
  logic        bad_cmd;
  logic        want_op;
  logic [15:0] want_len;
  err_e        rep_err;
  logic [7:0]  rep_status;

  always_comb begin
    nid = state_i.next_id + 32'd1;
    if (nid == '0) begin
      nid = 32'd1;
    end
    limit    = (max_att_i == '0) ? 4'd1 : max_att_i;
    att_inc  = state_i.attempt_count + 4'd1;
    bad_cmd  = (item_i.length == '0) || ({1'b0, item_i.length} > MaxLen) ||
               (item_i.deadline_ms == '0);
    want_op  = ~state_i.cur_is_write;
    want_len = state_i.cur_is_write ? 16'd0 : state_i.cur_length;

    // Reply checks are taken in priority order.
    rep_status = item_i.resp_status;
    if (!item_i.decode_ok) begin
      rep_err    = ERR_MALFORMED;
      rep_status = '0;
    end else if (item_i.resp_id != state_i.cur_id ||
                 item_i.resp_address != state_i.cur_address) begin
      rep_err = ERR_MISMATCH;
    end else if (item_i.resp_opcode == OP_ERROR) begin
      rep_err = ERR_REMOTE;
    end else if (item_i.resp_opcode != (want_op ? OP_DATA : OP_WACK) ||
                 item_i.resp_payload_len != want_len) begin
      rep_err = ERR_UNEXPECTED;
    end else begin
      rep_err = ERR_NONE;
    end
  end

  always_comb begin
    state_o   = state_i;
    res0_o    = '0;
    res1_o    = '0;
    num_res_o = 2'd0;
    case (item_i.req_type)
      REQ_READ, REQ_WRITE: begin
        if (state_i.phase == PH_IDLE) begin
          state_o.next_id = nid;
          num_res_o       = 2'd1;
          if (bad_cmd) begin
            res0_o = mk_res(ACT_FINAL, state_i.next_id, 1'b0, '0, '0, '0,
                            ERR_INVALID, '0, 4'd0, 1'b1);
          end else begin
            state_o.cur_is_write  = (item_i.req_type == REQ_WRITE);
            state_o.cur_id        = state_i.next_id;
            state_o.cur_address   = item_i.address;
            state_o.cur_length    = item_i.length;
            state_o.cur_deadline  = item_i.deadline_ms;
            state_o.attempt_count = 4'd1;
            state_o.phase         = item_i.link_up ? PH_REPLY : PH_CONNECT;
            res0_o = mk_res(item_i.link_up ? ACT_SEND : ACT_CONNECT, state_i.next_id,
                            (item_i.req_type == REQ_WRITE), item_i.address,
                            item_i.length, item_i.deadline_ms, ERR_NONE, '0,
                            4'd1, 1'b1);
          end
        end
      end
      REQ_CONNECT: begin
        if (state_i.phase == PH_CONNECT) begin
          num_res_o = 2'd1;
          if (item_i.link_up) begin
            state_o.phase = PH_REPLY;
            res0_o = mk_res(ACT_SEND, state_i.cur_id, state_i.cur_is_write,
                            state_i.cur_address, state_i.cur_length,
                            state_i.cur_deadline, ERR_NONE, '0,
                            state_i.attempt_count, 1'b1);
          end else begin
            state_o.phase = PH_IDLE;
            res0_o = mk_res(ACT_FINAL, state_i.cur_id, 1'b0, '0, '0, '0,
                            ERR_CONN_FAIL, '0, state_i.attempt_count, 1'b1);
          end
        end
      end
      REQ_REPLY: begin
        if (state_i.phase == PH_REPLY) begin
          if (item_i.reply_kind == RK_BYTES) begin
            num_res_o     = 2'd1;
            state_o.phase = PH_IDLE;
            res0_o = mk_res(ACT_FINAL, state_i.cur_id, 1'b0, '0, '0, '0,
                            rep_err, rep_status, state_i.attempt_count, 1'b1);
          end else begin
            // Transport error: close first, then retry or give up.
            num_res_o = 2'd2;
            res0_o = mk_res(ACT_CLOSE, state_i.cur_id, 1'b0, '0, '0, '0,
                            ERR_NONE, '0, state_i.attempt_count, 1'b0);
            if (!state_i.cur_is_write && state_i.attempt_count < limit &&
                item_i.reply_kind inside {RK_TIMEOUT, RK_DISC, RK_NOCONN}) begin
              state_o.attempt_count = att_inc;
              state_o.phase         = PH_CONNECT;
              res1_o = mk_res(ACT_CONNECT, state_i.cur_id, 1'b0, '0, '0, '0,
                              ERR_NONE, '0, att_inc, 1'b1);
            end else begin
              state_o.phase = PH_IDLE;
              res1_o = mk_res(ACT_FINAL, state_i.cur_id, 1'b0, '0, '0, '0,
                              (item_i.reply_kind == RK_TIMEOUT) ? ERR_TIMEOUT
                                                                : ERR_DISCONN,
                              '0, state_i.attempt_count, 1'b1);
            end
          end
        end
      end
      default: begin
        num_res_o = 2'd0;
      end
    endcase
  end

endmodule

// ===== hdl/mrrt_res_queue.sv =====
// ----------------------------------------------------------------------------
// mrrt_res_queue
// Small result queue that takes up to two words a cycle and gives one when popped.
// ----------------------------------------------------------------------------
module mrrt_res_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  push_num_i,
  input  mrrt_pkg::result_t           push0_i,
  input  mrrt_pkg::result_t           push1_i,
  input  logic                        pop_i,
  output mrrt_pkg::result_t           head_o,
  output logic [mrrt_pkg::RqCntW-1:0] count_o
);
  import mrrt_pkg::*;

  result_t             mem_q [RqDepth];
  logic [RqPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [RqPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [RqCntW-1:0]   cnt_q, cnt_d;
  logic [RqPtrW-1:0]   wr_ptr1;

  assign wr_ptr1 = wr_ptr_q + RqPtrW'(1);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + RqPtrW'(push_num_i);
    rd_ptr_d = rd_ptr_q + RqPtrW'(pop_i);
    cnt_d    = cnt_q + RqCntW'(push_num_i) - RqCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr1] <= push1_i;
    end
  end

endmodule

// ===== hdl/memory_request_retry_tracker.sv =====
// ----------------------------------------------------------------------------
// memory_request_retry_tracker
// Requester for a remote-memory link: issues IDs, drives connect, send and
// close steps, retries reads on transport errors and checks every reply.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  in       | to block  | in_valid_i / in_stall_o  | command, connect, reply
//  out      | from block| out_valid_o / out_stall_i| action and result fields
//  cfg      | to block  | cfg_valid_i / cfg_ready_o| max_read_attempts (4 bit)
//
// An accepted event waits in the input register until it is retired, then its
// one or two result words are written together into a four-word result queue.
// One event per cycle is taken while the queue has room for two words; the queue
// drains one word per cycle while the output is not stalled, so events that give
// two words halve the rate. Reset sets the ID counter to 1, the link phase to
// idle and attempt limit to 3; output stalls hold input once three words wait.
// ----------------------------------------------------------------------------
module memory_request_retry_tracker #(
  parameter int unsigned MAX_PAYLOAD = mrrt_pkg::MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  // Input events
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] address_i,
  input  logic [15:0] length_i,
  input  logic [15:0] deadline_ms_i,
  input  logic        link_up_i,
  input  logic [2:0]  reply_kind_i,
  input  logic        decode_ok_i,
  input  logic [1:0]  resp_opcode_i,
  input  logic [31:0] resp_id_i,
  input  logic [31:0] resp_address_i,
  input  logic [15:0] resp_payload_len_i,
  input  logic [7:0]  resp_status_i,
  // Results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic        send_is_write_o,
  output logic [31:0] req_tag_o,
  output logic [31:0] send_address_o,
  output logic [15:0] send_length_o,
  output logic [15:0] send_deadline_ms_o,
  output logic [3:0]  error_code_o,
  output logic [7:0]  peer_status_o,
  output logic [3:0]  attempts_o,
  output logic        last_o
);
  import mrrt_pkg::*;

  item_t             item_q;
  logic              item_vld_q, item_vld_d;
  state_t            state_q, state_d;
  logic [3:0]        max_att_q;
  result_t           res0, res1, head;
  logic [1:0]        num_res;
  logic [RqCntW-1:0] q_count;
  logic              retire;
  logic              load;
  logic              pop;

  // Room for two words is needed before an event may be retired.
  assign retire      = item_vld_q && (q_count <= RqCntW'(RqDepth - 2));
  assign in_stall_o  = item_vld_q && !retire;
  assign load        = in_valid_i && !in_stall_o;
  assign item_vld_d  = load || (item_vld_q && !retire);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (q_count != '0);
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      max_att_q  <= MaxAttemptsRst;
      state_q    <= '{next_id: 32'd1, phase: PH_IDLE, default: '0};
    end else begin
      item_vld_q <= item_vld_d;
      if (cfg_valid_i) begin
        max_att_q <= cfg_data_i;
      end
      if (retire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{req_type: req_type_i, address: address_i, length: length_i,
                  deadline_ms: deadline_ms_i, link_up: link_up_i,
                  reply_kind: reply_kind_i, decode_ok: decode_ok_i,
                  resp_opcode: resp_opcode_i, resp_id: resp_id_i,
                  resp_address: resp_address_i,
                  resp_payload_len: resp_payload_len_i,
                  resp_status: resp_status_i};
    end
  end

  mrrt_step #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .max_att_i(max_att_q),
    .state_o  (state_d),
    .res0_o   (res0),
    .res1_o   (res1),
    .num_res_o(num_res)
  );

  mrrt_res_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_num_i(retire ? num_res : 2'd0),
    .push0_i   (res0),
    .push1_i   (res1),
    .pop_i     (pop),
    .head_o    (head),
    .count_o   (q_count)
  );

  assign action_o           = head.action;
  assign send_is_write_o    = head.send_is_write;
  assign req_tag_o          = head.req_tag;
  assign send_address_o     = head.send_address;
  assign send_length_o      = head.send_length;
  assign send_deadline_ms_o = head.send_deadline_ms;
  assign error_code_o       = head.error_code;
  assign peer_status_o      = head.peer_status;
  assign attempts_o         = head.attempts;
  assign last_o             = head.last;

endmodule

// ===== test/tb_memory_request_retry_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_memory_request_retry_tracker
// Drives commands, connect outcomes and replies into the retry tracker and
// checks every result word against a cycle-free predictor of the link phases,
// request IDs and retry counting, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_memory_request_retry_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import mrrt_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [31:0] address_i = '0;
  logic [15:0] length_i = '0;
  logic [15:0] deadline_ms_i = '0;
  logic        link_up_i = 1'b0;
  logic [2:0]  reply_kind_i = '0;
  logic        decode_ok_i = 1'b0;
  logic [1:0]  resp_opcode_i = '0;
  logic [31:0] resp_id_i = '0;
  logic [31:0] resp_address_i = '0;
  logic [15:0] resp_payload_len_i = '0;
  logic [7:0]  resp_status_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  action_o;
  logic        send_is_write_o;
  logic [31:0] req_tag_o;
  logic [31:0] send_address_o;
  logic [15:0] send_length_o;
  logic [15:0] send_deadline_ms_o;
  logic [3:0]  error_code_o;
  logic [7:0]  peer_status_o;
  logic [3:0]  attempts_o;
  logic        last_o;

  // Predicted state of the requester.
  logic [31:0] id_counter = 32'd1;
  phase_e      link_phase = PH_IDLE;
  logic        cmd_write = 1'b0;
  logic [31:0] cmd_id = '0;
  logic [31:0] cmd_addr = '0;
  logic [15:0] cmd_len = '0;
  logic [15:0] cmd_deadline = '0;
  logic [3:0]  tries = '0;
  logic [3:0]  try_limit = MaxAttemptsRst;

  result_t     want_q[$];
  row_t        rows[$];
  int          fails = 0;
  bit          idle_on = 1'b1;
  bit          hold_ask = 1'b0;
  int          err_pct = 40;
  int          cfail_pct = 10;

  always #6ns clk_i = ~clk_i;

  memory_request_retry_tracker u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .address_i          (address_i),
    .length_i           (length_i),
    .deadline_ms_i      (deadline_ms_i),
    .link_up_i          (link_up_i),
    .reply_kind_i       (reply_kind_i),
    .decode_ok_i        (decode_ok_i),
    .resp_opcode_i      (resp_opcode_i),
    .resp_id_i          (resp_id_i),
    .resp_address_i     (resp_address_i),
    .resp_payload_len_i (resp_payload_len_i),
    .resp_status_i      (resp_status_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .action_o           (action_o),
    .send_is_write_o    (send_is_write_o),
    .req_tag_o          (req_tag_o),
    .send_address_o     (send_address_o),
    .send_length_o      (send_length_o),
    .send_deadline_ms_o (send_deadline_ms_o),
    .error_code_o       (error_code_o),
    .peer_status_o      (peer_status_o),
    .attempts_o         (attempts_o),
    .last_o             (last_o)
  );

  function automatic result_t word_of(action_e a, logic [31:0] id, err_e e,
                                      logic [7:0] st, logic [3:0] att, logic lst);
    result_t w;
    w = '0;
    w.action        = a;
    w.req_tag       = id;
    w.error_code    = e;
    w.peer_status   = st;
    w.attempts      = att;
    w.last          = lst;
    return w;
  endfunction

  function automatic result_t send_word();
    result_t w;
    w = word_of(ACT_SEND, cmd_id, ERR_NONE, 8'd0, tries, 1'b1);
    w.send_is_write    = cmd_write;
    w.send_address     = cmd_addr;
    w.send_length      = cmd_len;
    w.send_deadline_ms = cmd_deadline;
    return w;
  endfunction

  // Advances the predicted link state by one accepted word and queues the
  // result words that it causes.
  task automatic link_step(item_t it);
    logic [31:0] id;
    logic [3:0]  lim;
    err_e        e;
    logic [7:0]  st;
    lim = (try_limit == 4'd0) ? 4'd1 : try_limit;
    case (req_type_e'(it.req_type))
      REQ_READ, REQ_WRITE: begin
        if (link_phase == PH_IDLE) begin
          id = id_counter;
          id_counter = id_counter + 32'd1;
          if (id_counter == 32'd0) id_counter = 32'd1;
          if (it.length == 16'd0 || it.length > MaxPayloadDef || it.deadline_ms == 16'd0) begin
            want_q.push_back(word_of(ACT_FINAL, id, ERR_INVALID, 8'd0, 4'd0, 1'b1));
          end else begin
            cmd_write    = (it.req_type == REQ_WRITE);
            cmd_id       = id;
            cmd_addr     = it.address;
            cmd_len      = it.length;
            cmd_deadline = it.deadline_ms;
            tries        = 4'd1;
            if (it.link_up) begin
              link_phase = PH_REPLY;
              want_q.push_back(send_word());
            end else begin
              link_phase = PH_CONNECT;
              want_q.push_back(word_of(ACT_CONNECT, cmd_id, ERR_NONE, 8'd0, tries, 1'b1));
            end
          end
        end
      end
      REQ_CONNECT: begin
        if (link_phase == PH_CONNECT) begin
          if (it.link_up) begin
            link_phase = PH_REPLY;
            want_q.push_back(send_word());
          end else begin
            link_phase = PH_IDLE;
            want_q.push_back(word_of(ACT_FINAL, cmd_id, ERR_CONN_FAIL, 8'd0, tries, 1'b1));
          end
        end
      end
      default: begin
        if (link_phase == PH_REPLY) begin
          if (it.reply_kind == RK_BYTES) begin
            st = it.resp_status;
            if (!it.decode_ok) begin
              e  = ERR_MALFORMED;
              st = 8'd0;
            end else if (it.resp_id != cmd_id || it.resp_address != cmd_addr) begin
              e = ERR_MISMATCH;
            end else if (it.resp_opcode == OP_ERROR) begin
              e = ERR_REMOTE;
            end else if (it.resp_opcode != (cmd_write ? OP_WACK : OP_DATA) ||
                         it.resp_payload_len != (cmd_write ? 16'd0 : cmd_len)) begin
              e = ERR_UNEXPECTED;
            end else begin
              e = ERR_NONE;
            end
            link_phase = PH_IDLE;
            want_q.push_back(word_of(ACT_FINAL, cmd_id, e, st, tries, 1'b1));
          end else begin
            // Every transport error closes the link first. Kinds above the
            // named ones count as other errors and are never retried.
            want_q.push_back(word_of(ACT_CLOSE, cmd_id, ERR_NONE, 8'd0, tries, 1'b0));
            if (!cmd_write && tries < lim && it.reply_kind <= RK_NOCONN) begin
              tries = tries + 4'd1;
              link_phase = PH_CONNECT;
              want_q.push_back(word_of(ACT_CONNECT, cmd_id, ERR_NONE, 8'd0, tries, 1'b1));
            end else begin
              link_phase = PH_IDLE;
              e = (it.reply_kind == RK_TIMEOUT) ? ERR_TIMEOUT : ERR_DISCONN;
              want_q.push_back(word_of(ACT_FINAL, cmd_id, e, 8'd0, tries, 1'b1));
            end
          end
        end
      end
    endcase
  endtask

  function automatic item_t cmd_item(req_type_e t, logic [31:0] a, logic [15:0] len,
                                     logic [15:0] dl, logic up);
    item_t it;
    it = '0;
    it.req_type    = t;
    it.address     = a;
    it.length      = len;
    it.deadline_ms = dl;
    it.link_up     = up;
    return it;
  endfunction

  function automatic item_t conn_item(logic up);
    item_t it;
    it = '0;
    it.req_type = REQ_CONNECT;
    it.link_up  = up;
    return it;
  endfunction

  function automatic item_t reply_item(logic [2:0] k, logic dec, opcode_e op,
                                       logic [31:0] id, logic [31:0] a,
                                       logic [15:0] len, logic [7:0] st);
    item_t it;
    it = '0;
    it.req_type         = REQ_REPLY;
    it.reply_kind       = k;
    it.decode_ok        = dec;
    it.resp_opcode      = op;
    it.resp_id          = id;
    it.resp_address     = a;
    it.resp_payload_len = len;
    it.resp_status      = st;
    return it;
  endfunction

  task automatic add_row(item_t it, bit typed, result_t w);
    row_t r;
    r.it    = it;
    r.typed = typed;
    r.want  = w;
    rows.push_back(r);
  endtask

  // Offers one word, waits for it to be taken and predicts its results. A
  // typed row replaces the prediction with its own expected word.
  task automatic push_item(item_t it, bit typed, result_t w, output int n);
    int sz;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_type_i         <= it.req_type;
    address_i          <= it.address;
    length_i           <= it.length;
    deadline_ms_i      <= it.deadline_ms;
    link_up_i          <= it.link_up;
    reply_kind_i       <= it.reply_kind;
    decode_ok_i        <= it.decode_ok;
    resp_opcode_i      <= it.resp_opcode;
    resp_id_i          <= it.resp_id;
    resp_address_i     <= it.resp_address;
    resp_payload_len_i <= it.resp_payload_len;
    resp_status_i      <= it.resp_status;
    in_valid_i         <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sz = want_q.size();
    link_step(it);
    n = want_q.size() - sz;
    if (typed) begin
      repeat (n) void'(want_q.pop_back());
      want_q.push_back(w);
    end
  endtask

  // Mostly well-formed words for the current link phase, with random content;
  // the rest is left fully random and is often ignored.
  task automatic gen_item(output item_t it);
    int r;
    it.req_type         = 2'($urandom);
    it.address          = $urandom;
    it.length           = 16'($urandom);
    it.deadline_ms      = 16'($urandom);
    it.link_up          = 1'($urandom);
    it.reply_kind       = 3'($urandom);
    it.decode_ok        = 1'($urandom);
    it.resp_opcode      = 2'($urandom);
    it.resp_id          = $urandom;
    it.resp_address     = $urandom;
    it.resp_payload_len = 16'($urandom);
    it.resp_status      = 8'($urandom);
    if ($urandom_range(0, 99) < 7) return;
    case (link_phase)
      PH_IDLE: begin
        it.req_type = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
        r = $urandom_range(0, 99);
        if (r < 6) it.length = 16'd0;
        else if (r < 10) it.length = 16'($urandom_range(MaxPayloadDef + 1, 65535));
        else if (r < 14) it.length = 16'(MaxPayloadDef);
        else if (r < 20) it.length = 16'd1;
        else it.length = 16'($urandom_range(1, 64));
        it.deadline_ms = ($urandom_range(0, 99) < 5) ? 16'd0
                                                      : 16'($urandom_range(1, 65535));
      end
      PH_CONNECT: begin
        it.req_type = REQ_CONNECT;
        it.link_up  = ($urandom_range(0, 99) >= cfail_pct);
      end
      default: begin
        it.req_type = REQ_REPLY;
        if ($urandom_range(0, 99) < err_pct) begin
          it.reply_kind = 3'($urandom_range(1, 7));
        end else begin
          it.reply_kind = RK_BYTES;
          it.decode_ok  = ($urandom_range(0, 99) >= 8);
          if ($urandom_range(0, 99) < 85) it.resp_id = cmd_id;
          if ($urandom_range(0, 99) < 85) it.resp_address = cmd_addr;
          if ($urandom_range(0, 99) < 75) it.resp_opcode = cmd_write ? OP_WACK : OP_DATA;
          if ($urandom_range(0, 99) < 80) it.resp_payload_len = cmd_write ? 16'd0 : cmd_len;
        end
      end
    endcase
  endtask

  // Holds the sender off until every expected word has come, then lets the
  // pipeline settle in case an ignored word is still in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [3:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    try_limit = v;
  endtask

  task automatic run_random(int count, bit hold_mid, bit pause_mid);
    item_t it;
    int    n;
    int    done;
    done = 0;
    while (done < count) begin
      gen_item(it);
      push_item(it, 1'b0, '0, n);
      if (n > 0) begin
        done++;
        if (hold_mid && done == count / 4) hold_ask = 1'b1;
        if (pause_mid && done == count / 2) drain();
      end
    end
  endtask

  task automatic check_field(string nm, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
      fails++;
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : out_stall_drive
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        burst_left = $urandom_range(0, 6);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : result_check
    result_t w;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (want_q.size() == 0) begin
          $display("%0t: result word with nothing expected, action %0d id %0h",
                   $time, action_o, req_tag_o);
          fails++;
        end else begin
          w = want_q.pop_front();
          check_field("action", 32'(w.action), 32'(action_o));
          check_field("send_is_write", 32'(w.send_is_write), 32'(send_is_write_o));
          check_field("req_tag", w.req_tag, req_tag_o);
          check_field("send_address", w.send_address, send_address_o);
          check_field("send_length", 32'(w.send_length), 32'(send_length_o));
          check_field("send_deadline_ms", 32'(w.send_deadline_ms),
                      32'(send_deadline_ms_o));
          check_field("error_code", 32'(w.error_code), 32'(error_code_o));
          check_field("peer_status", 32'(w.peer_status), 32'(peer_status_o));
          check_field("attempts", 32'(w.attempts), 32'(attempts_o));
          check_field("last", 32'(w.last), 32'(last_o));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    result_t w;
    result_t none;
    int      n;
    none = '0;

    // Directed part, at the reset attempt limit of three.
    add_row(cmd_item(REQ_READ, 32'h0, 16'd0, 16'd5, 1'b1), 1'b1,
            word_of(ACT_FINAL, 32'd1, ERR_INVALID, 8'd0, 4'd0, 1'b1));
    add_row(cmd_item(REQ_WRITE, 32'h0, 16'd1025, 16'd1, 1'b1), 1'b1,
            word_of(ACT_FINAL, 32'd2, ERR_INVALID, 8'd0, 4'd0, 1'b1));
    add_row(cmd_item(REQ_READ, 32'h0, 16'd1, 16'd0, 1'b1), 1'b1,
            word_of(ACT_FINAL, 32'd3, ERR_INVALID, 8'd0, 4'd0, 1'b1));
    w = word_of(ACT_SEND, 32'd4, ERR_NONE, 8'd0, 4'd1, 1'b1);
    w.send_address     = 32'hFFFF_FFFF;
    w.send_length      = 16'd1024;
    w.send_deadline_ms = 16'hFFFF;
    add_row(cmd_item(REQ_READ, 32'hFFFF_FFFF, 16'd1024, 16'hFFFF, 1'b1), 1'b1, w);
    // A start and a connect while a reply is awaited are both dropped.
    add_row(cmd_item(REQ_WRITE, 32'h1, 16'd2, 16'd2, 1'b1), 1'b0, none);
    add_row(conn_item(1'b1), 1'b0, none);
    add_row(reply_item(RK_BYTES, 1'b1, OP_DATA, 32'd4, 32'hFFFF_FFFF, 16'd1024, 8'hFF),
            1'b1, word_of(ACT_FINAL, 32'd4, ERR_NONE, 8'hFF, 4'd1, 1'b1));
    add_row(conn_item(1'b1), 1'b0, none);
    add_row(reply_item(RK_BYTES, 1'b1, OP_DATA, 32'd4, 32'h0, 16'd0, 8'h0), 1'b0, none);
    add_row(cmd_item(REQ_WRITE, 32'h0, 16'd1, 16'd1, 1'b0), 1'b0, none);
    add_row(conn_item(1'b0), 1'b1,
            word_of(ACT_FINAL, 32'd5, ERR_CONN_FAIL, 8'd0, 4'd1, 1'b1));
    // A read that uses up all three attempts.
    add_row(cmd_item(REQ_READ, 32'h0000_1234, 16'd16, 16'd100, 1'b0), 1'b0, none);
    add_row(conn_item(1'b1), 1'b0, none);
    add_row(reply_item(RK_TIMEOUT, 1'b0, OP_DATA, 32'd0, 32'd0, 16'd0, 8'd0), 1'b0, none);
    add_row(conn_item(1'b1), 1'b0, none);
    add_row(reply_item(RK_DISC, 1'b0, OP_DATA, 32'd0, 32'd0, 16'd0, 8'd0), 1'b0, none);
    add_row(conn_item(1'b1), 1'b0, none);
    add_row(reply_item(RK_NOCONN, 1'b0, OP_DATA, 32'd0, 32'd0, 16'd0, 8'd0), 1'b0, none);
    // An out-of-range reply kind is an other error and ends the read at once.
    add_row(cmd_item(REQ_READ, 32'h8000_0000, 16'd8, 16'd1, 1'b1), 1'b0, none);
    add_row(reply_item(3'd7, 1'b0, OP_DATA, 32'd0, 32'd0, 16'd0, 8'd0), 1'b0, none);
    // Writes are not retried after a timeout.
    add_row(cmd_item(REQ_WRITE, 32'hA5A5_0000, 16'd4, 16'd20, 1'b1), 1'b0, none);
    add_row(reply_item(RK_TIMEOUT, 1'b0, OP_DATA, 32'd0, 32'd0, 16'd0, 8'd0), 1'b0, none);
    add_row(cmd_item(REQ_READ, 32'h5A5A_5A5A, 16'd32, 16'd7, 1'b1), 1'b0, none);
    add_row(reply_item(RK_BYTES, 1'b0, OP_DATA, 32'd9, 32'h5A5A_5A5A, 16'd32, 8'h5A),
            1'b1, word_of(ACT_FINAL, 32'd9, ERR_MALFORMED, 8'd0, 4'd1, 1'b1));
    add_row(cmd_item(REQ_READ, 32'h0000_0010, 16'd64, 16'd3, 1'b1), 1'b0, none);
    add_row(reply_item(RK_OTHER, 1'b0, OP_DATA, 32'd0, 32'd0, 16'd0, 8'd0), 1'b0, none);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) push_item(rows[i].it, rows[i].typed, rows[i].want, n);

    drain();
    write_limit(4'd1);
    run_random(300, 1'b0, 1'b0);

    // Long retry chains at the top limit, with the receiver held off once.
    drain();
    write_limit(4'd15);
    err_pct   = 85;
    cfail_pct = 3;
    run_random(400, 1'b1, 1'b0);

    drain();
    write_limit(4'd0);
    err_pct   = 50;
    cfail_pct = 10;
    run_random(300, 1'b0, 1'b0);

    drain();
    write_limit(4'($urandom_range(2, 14)));
    err_pct = 45;
    run_random(400, 1'b0, 1'b1);

    // Last stretch runs without any idling on either side.
    drain();
    write_limit(MaxAttemptsRst);
    idle_on = 1'b0;
    err_pct = 40;
    run_random(600, 1'b0, 1'b0);

    drain();
    if (fails == 0 && want_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
